// ===== sv/stretch_spring_damper_force_defines.svh =====
// assertion macros for the spring-damper force block
`ifndef STRETCH_SPRING_DAMPER_FORCE_DEFINES_SVH
`define STRETCH_SPRING_DAMPER_FORCE_DEFINES_SVH

// checked only outside reset
`define SSDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define SSDF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/ssdf_pkg.sv =====
// shared widths, register codes, side payload types and helpers
package ssdf_pkg;

  localparam int AXES      = 3;
  localparam int JAC_N     = 6;
  localparam int CFG_W     = 31;
  localparam int IN_W      = 32;
  localparam int DIF_W     = 33;
  localparam int SQ_W      = 66;
  localparam int ROOT_W    = 35;
  localparam int FRAC      = 30;
  localparam int QUO_W     = 31;
  localparam int NUM_W     = ROOT_W + FRAC;
  localparam int DIV_LANES = 4;
  localparam int DT_W      = 49;
  localparam int T_W       = 50;
  localparam int EXT_LO    = 18;
  localparam int T_LO      = 25;
  localparam int WIDE_W    = 66;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_REST_LENGTH      = 2'd0;
  localparam cfg_idx_t CFG_SPRING_STIFFNESS = 2'd1;
  localparam cfg_idx_t CFG_DAMPING_GAIN     = 2'd2;

  localparam logic [CFG_W-1:0] REST_LENGTH_RST = 31'd65536;

  // row and column of each distinct jacobian entry: xx xy xz yy yz zz
  localparam logic [1:0] JAC_I [JAC_N] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] JAC_J [JAC_N] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

  // side payload carried through the square root pipeline
  typedef struct packed {
    logic [AXES-1:0]             sgn;
    logic [AXES-1:0][DIF_W-1:0]  mag;
    logic [AXES-1:0][DT_W-1:0]   dt;
  } sq_side_t;

  // side payload carried through the divider pipeline
  typedef struct packed {
    logic [AXES-1:0]             sgn;
    logic [AXES-1:0][DT_W-1:0]   dt;
    logic [T_W-1:0]              t;
    logic                        act;
  } div_side_t;

  // arithmetic shift right rounding toward zero
  function automatic logic signed [WIDE_W-1:0] shr_tz(input logic signed [WIDE_W-1:0] v,
                                                       input int unsigned sh);
    logic signed [WIDE_W-1:0] bias;
    logic signed [WIDE_W-1:0] sum;
    bias = (WIDE_W'(1) << sh) - WIDE_W'(1);
    sum  = v + (v[WIDE_W-1] ? bias : WIDE_W'(0));
    return sum >>> sh;
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [IN_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [IN_W-1:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[IN_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/ssdf_isqrt.sv =====
// pipelined integer square root, one root bit per stage
module ssdf_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ce,
  input  logic                          in_valid,
  input  logic [ssdf_pkg::SQ_W-1:0]     in_radicand,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic [ssdf_pkg::ROOT_W-1:0]   out_root,
  output logic [SIDE_W-1:0]             out_side
);

  localparam int RW  = ssdf_pkg::ROOT_W;
  localparam int OPW = 2 * RW;

  logic              vld_r  [RW];
  logic [OPW-1:0]    op_r   [RW];
  logic [OPW-1:0]    res_r  [RW];
  logic [SIDE_W-1:0] side_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam logic [OPW-1:0] ONE = OPW'(1) << (2 * (RW - 1 - k));
    logic              v_i;
    logic [OPW-1:0]    op_i;
    logic [OPW-1:0]    res_i;
    logic [SIDE_W-1:0] side_i;
    logic [OPW-1:0]    trial;
    logic              take;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign op_i   = OPW'(in_radicand);
      assign res_i  = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = vld_r[k-1];
      assign op_i   = op_r[k-1];
      assign res_i  = res_r[k-1];
      assign side_i = side_r[k-1];
    end

    // trial subtract of the next root bit
    assign trial = res_i + ONE;
    assign take  = (op_i >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ce) begin
        vld_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        op_r[k]   <= take ? (op_i - trial) : op_i;
        res_r[k]  <= take ? ((res_i >> 1) + ONE) : (res_i >> 1);
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign out_root  = res_r[RW-1][RW-1:0];
  assign out_side  = side_r[RW-1];

endmodule

// ===== sv/ssdf_div.sv =====
// pipelined restoring divider, four numerators over one divisor, one quotient bit per stage
module ssdf_div #(
  parameter int SIDE_W = 1
) (
  input  logic                                                       clk,
  input  logic                                                       rst_n,
  input  logic                                                       ce,
  input  logic                                                       in_valid,
  input  logic [ssdf_pkg::DIV_LANES-1:0][ssdf_pkg::NUM_W-1:0]        in_num,
  input  logic [ssdf_pkg::ROOT_W-1:0]                                in_den,
  input  logic [SIDE_W-1:0]                                          in_side,
  output logic                                                       out_valid,
  output logic [ssdf_pkg::DIV_LANES-1:0][ssdf_pkg::QUO_W-1:0]        out_quo,
  output logic [SIDE_W-1:0]                                          out_side
);

  localparam int NL = ssdf_pkg::DIV_LANES;
  localparam int NW = ssdf_pkg::NUM_W;
  localparam int DW = ssdf_pkg::ROOT_W;
  localparam int QW = ssdf_pkg::QUO_W;

  logic                      vld_r  [QW];
  logic [NL-1:0][NW-1:0]     rem_r  [QW];
  logic [NL-1:0][QW-1:0]     quo_r  [QW];
  logic [DW-1:0]             den_r  [QW];
  logic [SIDE_W-1:0]         side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                  v_i;
    logic [NL-1:0][NW-1:0] rem_i;
    logic [NL-1:0][QW-1:0] quo_i;
    logic [DW-1:0]         den_i;
    logic [SIDE_W-1:0]     side_i;
    logic [NW-1:0]         sub;
    logic [NL-1:0][NW-1:0] rem_nxt;
    logic [NL-1:0][QW-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = in_num;
      assign quo_i  = '0;
      assign den_i  = in_den;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = vld_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign quo_i  = quo_r[k-1];
      assign den_i  = den_r[k-1];
      assign side_i = side_r[k-1];
    end

    // shifted divisor for this quotient bit
    assign sub = NW'(den_i) << (QW - 1 - k);

    always_comb begin
      for (int l = 0; l < NL; l++) begin
        if (rem_i[l] >= sub) begin
          rem_nxt[l] = rem_i[l] - sub;
          quo_nxt[l] = quo_i[l] | (QW'(1) << (QW - 1 - k));
        end else begin
          rem_nxt[l] = rem_i[l];
          quo_nxt[l] = quo_i[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ce) begin
        vld_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k]  <= rem_nxt;
        quo_r[k]  <= quo_nxt;
        den_r[k]  <= den_i;
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

// ===== sv/stretch_spring_damper_force.sv =====
// top level: stretch spring-damper force and position jacobian between two particles
//
// Fully pipelined: one particle pair is taken per clock unless the output is
// stalled. The pipeline depth is dominated by the 35-stage square root of the
// squared distance and the 31-stage divider that forms the unit direction and
// the stretch ratio; the remaining stages are single 32-bit-class multiplies
// and adds. A stall on the output freezes the whole pipeline, so input ready
// follows output ready whenever a result is held. Configuration registers may be
// written only while no pair is in flight.
module stretch_spring_damper_force (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            in_pos_a_x,
  input  logic signed [31:0]            in_pos_a_y,
  input  logic signed [31:0]            in_pos_a_z,
  input  logic signed [31:0]            in_vel_a_x,
  input  logic signed [31:0]            in_vel_a_y,
  input  logic signed [31:0]            in_vel_a_z,
  input  logic signed [31:0]            in_pos_b_x,
  input  logic signed [31:0]            in_pos_b_y,
  input  logic signed [31:0]            in_pos_b_z,
  input  logic signed [31:0]            in_vel_b_x,
  input  logic signed [31:0]            in_vel_b_y,
  input  logic signed [31:0]            in_vel_b_z,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            out_force_x,
  output logic signed [31:0]            out_force_y,
  output logic signed [31:0]            out_force_z,
  output logic signed [31:0]            out_jac_xx,
  output logic signed [31:0]            out_jac_xy,
  output logic signed [31:0]            out_jac_xz,
  output logic signed [31:0]            out_jac_yy,
  output logic signed [31:0]            out_jac_yz,
  output logic signed [31:0]            out_jac_zz,
  output logic                          out_tension_active,
  // configuration
  input  logic                          cfg_we,
  input  ssdf_pkg::cfg_idx_t            cfg_index,
  input  logic [ssdf_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int AX  = ssdf_pkg::AXES;
  localparam int JN  = ssdf_pkg::JAC_N;
  localparam int DFW = ssdf_pkg::DIF_W;
  localparam int RW  = ssdf_pkg::ROOT_W;
  localparam int QW  = ssdf_pkg::QUO_W;
  localparam int NW  = ssdf_pkg::NUM_W;
  localparam int FR  = ssdf_pkg::FRAC;
  localparam int TW  = ssdf_pkg::T_W;
  localparam int TL  = ssdf_pkg::T_LO;
  localparam int EL  = ssdf_pkg::EXT_LO;
  localparam int WW  = ssdf_pkg::WIDE_W;
  localparam int CW  = ssdf_pkg::CFG_W;
  localparam int DTW = ssdf_pkg::DT_W;

  // configuration registers
  logic [CW-1:0] rest_length_r;
  logic [CW-1:0] spring_stiffness_r;
  logic [CW-1:0] damping_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_length_r      <= ssdf_pkg::REST_LENGTH_RST;
      spring_stiffness_r <= '0;
      damping_gain_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ssdf_pkg::CFG_REST_LENGTH:      rest_length_r      <= cfg_wdata;
        ssdf_pkg::CFG_SPRING_STIFFNESS: spring_stiffness_r <= cfg_wdata;
        ssdf_pkg::CFG_DAMPING_GAIN:     damping_gain_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // whole pipeline advances when the output register is free or drained
  logic ce;
  logic out_valid_r;
  assign ce       = !out_valid_r || out_ready;
  assign in_ready = ce;

  logic signed [31:0] pos_a [AX];
  logic signed [31:0] pos_b [AX];
  logic signed [31:0] vel_a [AX];
  logic signed [31:0] vel_b [AX];
  assign pos_a = '{in_pos_a_x, in_pos_a_y, in_pos_a_z};
  assign pos_b = '{in_pos_b_x, in_pos_b_y, in_pos_b_z};
  assign vel_a = '{in_vel_a_x, in_vel_a_y, in_vel_a_z};
  assign vel_b = '{in_vel_b_x, in_vel_b_y, in_vel_b_z};

  // valid bits of the stages held in this module
  logic v1_r, v2_r, v3_r, va_r, vb_r, vc_r;
  logic vd_r, ve_r, vf_r, vg_r, vh_r, vi_r, vj_r, vk_r;
  logic sq_vo, dv_vo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      va_r <= 1'b0; vb_r <= 1'b0; vc_r <= 1'b0;
      vd_r <= 1'b0; ve_r <= 1'b0; vf_r <= 1'b0; vg_r <= 1'b0;
      vh_r <= 1'b0; vi_r <= 1'b0; vj_r <= 1'b0; vk_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r;
      va_r <= sq_vo;    vb_r <= va_r; vc_r <= vb_r;
      vd_r <= dv_vo;    ve_r <= vd_r; vf_r <= ve_r; vg_r <= vf_r;
      vh_r <= vg_r;     vi_r <= vh_r; vj_r <= vi_r; vk_r <= vj_r;
      out_valid_r <= vk_r;
    end
  end

  // stage 1: position and velocity differences
  logic signed [DFW-1:0] d1_r  [AX];
  logic signed [DFW-1:0] dv1_r [AX];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < AX; i++) begin
        d1_r[i]  <= {pos_a[i][31], pos_a[i]} - {pos_b[i][31], pos_b[i]};
        dv1_r[i] <= {vel_a[i][31], vel_a[i]} - {vel_b[i][31], vel_b[i]};
      end
    end
  end

  // stage 2: squares, damping products, magnitudes
  logic signed [WW-1:0]  sq2_r   [AX];
  logic signed [64:0]    dp2_r   [AX];
  logic [DFW-1:0]        mag2_r  [AX];
  logic [AX-1:0]         sgn2_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < AX; i++) begin
        sq2_r[i]  <= WW'(d1_r[i]) * WW'(d1_r[i]);
        dp2_r[i]  <= $signed({1'b0, damping_gain_r}) * dv1_r[i];
        mag2_r[i] <= d1_r[i][DFW-1] ? $unsigned(-d1_r[i]) : $unsigned(d1_r[i]);
        sgn2_r[i] <= d1_r[i][DFW-1];
      end
    end
  end

  // stage 3: squared length and damping terms
  logic [ssdf_pkg::SQ_W-1:0] sum3_r;
  ssdf_pkg::sq_side_t        sqs3_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      sum3_r     <= $unsigned(sq2_r[0]) + $unsigned(sq2_r[1]) + $unsigned(sq2_r[2]);
      sqs3_r.sgn <= sgn2_r;
      for (int i = 0; i < AX; i++) begin
        sqs3_r.mag[i] <= mag2_r[i];
        sqs3_r.dt[i]  <= DTW'(-ssdf_pkg::shr_tz(WW'(dp2_r[i]), 16));
      end
    end
  end

  // length by square root
  logic [RW-1:0]      len_o;
  ssdf_pkg::sq_side_t sqs_o;

  ssdf_isqrt #(
    .SIDE_W ($bits(ssdf_pkg::sq_side_t))
  ) u_isqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .ce          (ce),
    .in_valid    (v3_r),
    .in_radicand (sum3_r),
    .in_side     (sqs3_r),
    .out_valid   (sq_vo),
    .out_root    (len_o),
    .out_side    (sqs_o)
  );

  // stage a: extension and tension decision
  logic [RW-1:0]      len_a_r, ext_a_r;
  logic               act_a_r;
  ssdf_pkg::sq_side_t sqs_a_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      len_a_r <= len_o;
      ext_a_r <= len_o - RW'(rest_length_r);
      act_a_r <= (spring_stiffness_r != '0) && (len_o != '0) && (len_o >= RW'(rest_length_r));
      sqs_a_r <= sqs_o;
    end
  end

  // stage b: stiffness times extension, two partial products
  logic [CW+EL-1:0]      tpl_b_r;
  logic [CW+RW-EL-1:0]   tph_b_r;
  logic [RW-1:0]         len_b_r, ext_b_r;
  logic                  act_b_r;
  ssdf_pkg::sq_side_t    sqs_b_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      tpl_b_r <= (CW+EL)'(spring_stiffness_r) * (CW+EL)'(ext_a_r[EL-1:0]);
      tph_b_r <= (CW+RW-EL)'(spring_stiffness_r) * (CW+RW-EL)'(ext_a_r[RW-1:EL]);
      len_b_r <= len_a_r;
      ext_b_r <= ext_a_r;
      act_b_r <= act_a_r;
      sqs_b_r <= sqs_a_r;
    end
  end

  // stage c: tension magnitude and divider operands
  logic [WW-1:0]                      tsum;
  logic [ssdf_pkg::DIV_LANES-1:0][NW-1:0] num_c_r;
  logic [RW-1:0]                      len_c_r;
  ssdf_pkg::div_side_t                dvs_c_r;

  assign tsum = (WW'(tph_b_r) << EL) + WW'(tpl_b_r);

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < AX; i++) begin
        num_c_r[i] <= NW'(sqs_b_r.mag[i]) << FR;
      end
      num_c_r[AX] <= NW'(ext_b_r) << FR;
      len_c_r     <= len_b_r;
      dvs_c_r.sgn <= sqs_b_r.sgn;
      dvs_c_r.dt  <= sqs_b_r.dt;
      dvs_c_r.t   <= tsum[TW+15:16];
      dvs_c_r.act <= act_b_r;
    end
  end

  // unit direction and stretch ratio by division
  logic [ssdf_pkg::DIV_LANES-1:0][QW-1:0] quo_o;
  ssdf_pkg::div_side_t                    dvs_o;

  ssdf_div #(
    .SIDE_W ($bits(ssdf_pkg::div_side_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (vc_r),
    .in_num    (num_c_r),
    .in_den    (len_c_r),
    .in_side   (dvs_c_r),
    .out_valid (dv_vo),
    .out_quo   (quo_o),
    .out_side  (dvs_o)
  );

  // stage d: signed direction, tension partial products
  logic signed [31:0]     n_d_r   [AX];
  logic [TL+QW-1:0]       tpl_d_r [AX];
  logic [TW-TL+QW-1:0]    tph_d_r [AX];
  logic [QW-1:0]          s_d_r;
  ssdf_pkg::div_side_t    dvs_d_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < AX; i++) begin
        n_d_r[i]   <= dvs_o.sgn[i] ? -$signed({1'b0, quo_o[i]}) : $signed({1'b0, quo_o[i]});
        tpl_d_r[i] <= (TL+QW)'(dvs_o.t[TL-1:0]) * (TL+QW)'(quo_o[i]);
        tph_d_r[i] <= (TW-TL+QW)'(dvs_o.t[TW-1:TL]) * (TW-TL+QW)'(quo_o[i]);
      end
      s_d_r   <= quo_o[AX];
      dvs_d_r <= dvs_o;
    end
  end

  // stage e: direction outer products, tension per axis
  localparam int TMW = TW + QW - FR;
  logic signed [63:0]     nnp_e_r [JN];
  logic [TMW-1:0]         tm_e_r  [AX];
  logic [QW-1:0]          s_e_r;
  ssdf_pkg::div_side_t    dvs_e_r;
  logic [TW+QW-1:0]       tmsum   [AX];

  always_comb begin
    for (int i = 0; i < AX; i++) begin
      tmsum[i] = ((TW+QW)'(tph_d_r[i]) << TL) + (TW+QW)'(tpl_d_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < JN; k++) begin
        nnp_e_r[k] <= 64'(n_d_r[ssdf_pkg::JAC_I[k]]) * 64'(n_d_r[ssdf_pkg::JAC_J[k]]);
      end
      for (int i = 0; i < AX; i++) begin
        tm_e_r[i] <= tmsum[i][TW+QW-1:FR];
      end
      s_e_r   <= s_d_r;
      dvs_e_r <= dvs_d_r;
    end
  end

  // stage f: truncated outer products, signed and gated tension
  logic signed [31:0]     nn_f_r [JN];
  logic signed [TMW:0]    ft_f_r [AX];
  logic [QW-1:0]          s_f_r;
  logic                   act_f_r;
  logic [AX-1:0][DTW-1:0] dt_f_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < JN; k++) begin
        nn_f_r[k] <= 32'(ssdf_pkg::shr_tz(WW'(nnp_e_r[k]), FR));
      end
      for (int i = 0; i < AX; i++) begin
        if (!dvs_e_r.act) begin
          ft_f_r[i] <= '0;
        end else if (dvs_e_r.sgn[i]) begin
          ft_f_r[i] <= $signed({1'b0, tm_e_r[i]});
        end else begin
          ft_f_r[i] <= -$signed({1'b0, tm_e_r[i]});
        end
      end
      s_f_r   <= s_e_r;
      act_f_r <= dvs_e_r.act;
      dt_f_r  <= dvs_e_r.dt;
    end
  end

  // stage g: identity minus outer product, force sum
  localparam int FSW = TMW + 2;
  logic signed [32:0]     dd_g_r [JN];
  logic signed [31:0]     nn_g_r [JN];
  logic signed [FSW-1:0]  fs_g_r [AX];
  logic [QW-1:0]          s_g_r;
  logic                   act_g_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < JN; k++) begin
        dd_g_r[k] <= ((ssdf_pkg::JAC_I[k] == ssdf_pkg::JAC_J[k]) ? (33'sd1 <<< FR) : 33'sd0)
                     - 33'(nn_f_r[k]);
        nn_g_r[k] <= nn_f_r[k];
      end
      for (int i = 0; i < AX; i++) begin
        fs_g_r[i] <= FSW'(ft_f_r[i]) + FSW'($signed(dt_f_r[i]));
      end
      s_g_r   <= s_f_r;
      act_g_r <= act_f_r;
    end
  end

  // stage h: stretch ratio times (identity minus outer product)
  logic signed [64:0]     sdp_h_r [JN];
  logic signed [31:0]     nn_h_r  [JN];
  logic signed [FSW-1:0]  fs_h_r  [AX];
  logic                   act_h_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < JN; k++) begin
        sdp_h_r[k] <= $signed({1'b0, s_g_r}) * dd_g_r[k];
      end
      nn_h_r  <= nn_g_r;
      fs_h_r  <= fs_g_r;
      act_h_r <= act_g_r;
    end
  end

  // stage i: truncate the scaled term
  logic signed [32:0]     sd_i_r [JN];
  logic signed [31:0]     nn_i_r [JN];
  logic signed [FSW-1:0]  fs_i_r [AX];
  logic                   act_i_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < JN; k++) begin
        sd_i_r[k] <= 33'(ssdf_pkg::shr_tz(WW'(sdp_h_r[k]), FR));
      end
      nn_i_r  <= nn_h_r;
      fs_i_r  <= fs_h_r;
      act_i_r <= act_h_r;
    end
  end

  // stage j: jacobian matrix before stiffness
  logic signed [33:0]     m_j_r  [JN];
  logic signed [FSW-1:0]  fs_j_r [AX];
  logic                   act_j_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < JN; k++) begin
        m_j_r[k] <= 34'(nn_i_r[k]) + 34'(sd_i_r[k]);
      end
      fs_j_r  <= fs_i_r;
      act_j_r <= act_i_r;
    end
  end

  // stage k: scale by negated stiffness
  logic signed [WW-1:0]   jp_k_r [JN];
  logic signed [FSW-1:0]  fs_k_r [AX];
  logic                   act_k_r;
  logic signed [31:0]     nstiff;

  assign nstiff = -$signed({1'b0, spring_stiffness_r});

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < JN; k++) begin
        jp_k_r[k] <= WW'(nstiff) * WW'(m_j_r[k]);
      end
      fs_k_r  <= fs_j_r;
      act_k_r <= act_j_r;
    end
  end

  // output register: truncate, gate and saturate
  logic signed [31:0] force_r [AX];
  logic signed [31:0] jac_r   [JN];
  logic               act_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < AX; i++) begin
        force_r[i] <= ssdf_pkg::sat32(WW'(fs_k_r[i]));
      end
      for (int k = 0; k < JN; k++) begin
        jac_r[k] <= act_k_r ? ssdf_pkg::sat32(ssdf_pkg::shr_tz(jp_k_r[k], FR)) : 32'sd0;
      end
      act_r <= act_k_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_force_x        = force_r[0];
  assign out_force_y        = force_r[1];
  assign out_force_z        = force_r[2];
  assign out_jac_xx         = jac_r[0];
  assign out_jac_xy         = jac_r[1];
  assign out_jac_xz         = jac_r[2];
  assign out_jac_yy         = jac_r[3];
  assign out_jac_yz         = jac_r[4];
  assign out_jac_zz         = jac_r[5];
  assign out_tension_active = act_r;

endmodule

// ===== sv/ssdf_checker.sv =====
// port-level checks of the spring-damper force block, bound to the top level
`include "stretch_spring_damper_force_defines.svh"

module ssdf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_force_x,
  input logic signed [31:0] out_jac_xx,
  input logic signed [31:0] out_jac_xy,
  input logic signed [31:0] out_jac_xz,
  input logic signed [31:0] out_jac_yy,
  input logic signed [31:0] out_jac_yz,
  input logic signed [31:0] out_jac_zz,
  input logic               out_tension_active
);

  // a held result stays put until its transfer
  `SSDF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_force_x) && $stable(out_jac_xx), "result changed while stalled")

  // with the output register empty the pipeline must take input
  `SSDF_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input blocked with empty output")

  // without tension the jacobian is all zero
  `SSDF_ASSERT(a_jac_zero, out_valid && !out_tension_active |-> out_jac_xx == 32'sd0 && out_jac_xy == 32'sd0 && out_jac_xz == 32'sd0 && out_jac_yy == 32'sd0 && out_jac_yz == 32'sd0 && out_jac_zz == 32'sd0, "jacobian set without tension")

  // reset empties the pipeline
  `SSDF_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind stretch_spring_damper_force ssdf_checker u_ssdf_checker (.*);
